>>> rtl/core/pfla_pkg.sv
`timescale 1ns / 1ps

package pfla_pkg;

   localparam int OP_W     = 2;
   localparam int ADDR_W   = 32;
   localparam int STATUS_W = 2;
   localparam int PF_W     = 11;

   localparam logic [OP_W-1:0] OP_ALLOC      = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE       = 2'd1;
   localparam logic [OP_W-1:0] OP_FREE_RANGE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

   typedef logic [ADDR_W-1:0] addr_type;

   // number of trailing zero bits of a nonzero constant
   function automatic int trailing_zeros(input longint unsigned val);
      int n;
      n = 0;
      for (int i = 0; i < 40; i++) begin
         if (n == i && val[i] == 1'b0) begin
            n = i + 1;
         end
      end
      return n;
   endfunction

   // inverse of an odd constant modulo 2**32, newton iteration
   function automatic addr_type odd_inverse(input addr_type d);
      addr_type inv;
      inv = d;
      for (int i = 0; i < 5; i++) begin
         inv = inv * (addr_type'(2) - d * inv);
      end
      return inv;
   endfunction

endpackage

>>> rtl/core/page_free_list_allocator_unit.sv
`timescale 1ns / 1ps

// channel   | ports                                              | direction
// ----------+----------------------------------------------------+----------
// request   | start, busy (out), req_operation, req_address,     | in
//           | req_end_address                                    |
// response  | rsp_valid, rsp_page_address, rsp_status,           | out
//           | rsp_pages_free                                     |
//
// allocate and single free go through the eval state to the registered response strobe,
// and a new word is accepted only once busy is low again; range free goes through eval,
// the end address check and the push state, one stack write per cycle until the range
// ends or the stack fills; a misaligned end address alone stops it at that check
// reset clears the state, the response strobe and the stack pointer; stack contents are not cleared
// busy is high from the accepting edge until the response strobe cycle
// the response is a one-cycle strobe and cannot be stalled by the receiver
module page_free_list_allocator_unit #(
   parameter int PAGE_WORDS = 256,
   parameter int MAX_PAGES  = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [pfla_pkg::OP_W-1:0]          req_operation,
   input  logic [pfla_pkg::ADDR_W-1:0]        req_address,
   input  logic [pfla_pkg::ADDR_W-1:0]        req_end_address,
   output logic                               rsp_valid,
   output logic [pfla_pkg::ADDR_W-1:0]        rsp_page_address,
   output logic [pfla_pkg::STATUS_W-1:0]      rsp_status,
   output logic [pfla_pkg::PF_W-1:0]          rsp_pages_free
);
   import pfla_pkg::*;

   localparam longint unsigned PAGE_BYTES = longint'(PAGE_WORDS) * 4;
   localparam int TZ = trailing_zeros(PAGE_BYTES);
   localparam logic [ADDR_W-1:0] LOW_MASK = ADDR_W'((64'd1 << TZ) - 64'd1);
   localparam longint unsigned OddDiv = PAGE_BYTES >> TZ;
   localparam logic [ADDR_W-1:0] ODD_INV = odd_inverse(ADDR_W'(OddDiv));
   localparam logic [ADDR_W-1:0] ODD_LIMIT = ADDR_W'(64'hFFFF_FFFF / OddDiv);
   localparam logic [ADDR_W:0] PAGE_STEP = (ADDR_W + 1)'(PAGE_BYTES);

   localparam int CW = $clog2(MAX_PAGES + 1);
   localparam int AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_PAGES);
   localparam int DW = ADDR_W - 2;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EVAL = 2'd1;
   localparam logic [1:0] S_CHKE = 2'd2;
   localparam logic [1:0] S_PUSH = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [ADDR_W-1:0]   end_ff, end_in;
   logic [ADDR_W:0]     cur_ff, cur_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [ADDR_W-1:0]   prod_ff, prod_in;
   logic                low_zero_ff, low_zero_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]   rsp_pa_ff, rsp_pa_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;
   logic [PF_W-1:0]     rsp_pf_ff, rsp_pf_in;

   logic [DW-1:0]       stack_mem [MAX_PAGES];
   logic [DW-1:0]       rd_data_ff;
   logic                mem_we;
   logic [DW-1:0]       mem_wdata;
   logic [CW-1:0]       rd_sum;
   logic [AW-1:0]       rd_idx;
   logic [AW-1:0]       wr_idx;

   logic [ADDR_W-1:0]   mul_src;
   logic [ADDR_W-1:0]   mul_full;
   logic                aligned;
   logic                accept;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   // exact divisibility by the odd part: x * inv mod 2**32 does not exceed the limit
   assign mul_src  = (state_ff == S_IDLE) ? req_address : end_ff;
   assign mul_full = (mul_src >> TZ) * ODD_INV;
   assign prod_in     = mul_full;
   assign low_zero_in = ((mul_src & LOW_MASK) == '0);
   assign aligned     = low_zero_ff && (prod_ff <= ODD_LIMIT);

   assign rd_sum = count_ff - CW'(1);
   assign rd_idx = rd_sum[AW-1:0];
   assign wr_idx = count_ff[AW-1:0];

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      end_in       = end_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_pa_in    = '0;
      rsp_st_in    = ST_OK;
      mem_we       = 1'b0;
      mem_wdata    = addr_ff[ADDR_W-1:2];
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_operation;
               addr_in  = req_address;
               end_in   = req_end_address;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            state_in     = S_IDLE;
            rsp_valid_in = 1'b1;
            case (op_ff)
               OP_ALLOC: begin
                  if (count_ff == '0) begin
                     rsp_st_in = ST_EMPTY;
                  end else begin
                     count_in  = rd_sum;
                     rsp_pa_in = {rd_data_ff, 2'b00};
                  end
               end
               OP_FREE: begin
                  if (!aligned) begin
                     rsp_st_in = ST_MISALIGNED;
                  end else if (count_ff >= MAX_COUNT) begin
                     rsp_st_in = ST_FULL;
                  end else begin
                     mem_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
               OP_FREE_RANGE: begin
                  if (!aligned) begin
                     rsp_st_in = ST_MISALIGNED;
                  end else begin
                     // end address check still to come
                     rsp_valid_in = 1'b0;
                     state_in     = S_CHKE;
                  end
               end
               default: begin
               end
            endcase
         end
         S_CHKE: begin
            if (!aligned) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = ST_MISALIGNED;
               state_in     = S_IDLE;
            end else begin
               cur_in   = {1'b0, addr_ff};
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            mem_wdata = cur_ff[ADDR_W-1:2];
            if (cur_ff >= {1'b0, end_ff}) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (count_ff >= MAX_COUNT) begin
               rsp_valid_in = 1'b1;
               rsp_st_in    = ST_FULL;
               state_in     = S_IDLE;
            end else begin
               mem_we   = 1'b1;
               count_in = count_ff + CW'(1);
               cur_in   = cur_ff + PAGE_STEP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      rsp_pf_in = PF_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      end_ff      <= end_in;
      cur_ff      <= cur_in;
      prod_ff     <= prod_in;
      low_zero_ff <= low_zero_in;
      rsp_pa_ff   <= rsp_pa_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_pf_ff   <= rsp_pf_in;
   end

   // stack memory, top of stack is read every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[wr_idx] <= mem_wdata;
      end
      rd_data_ff <= stack_mem[rd_idx];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_page_address = rsp_pa_ff;
   assign rsp_status       = rsp_st_ff;
   assign rsp_pages_free   = rsp_pf_ff;

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("stack pointer beyond capacity");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (count_ff < MAX_COUNT) && (state_ff != S_IDLE))
      else $error("stack write outside a request or on a full stack");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && !rsp_valid)
      else $error("request accepted without going busy");

   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && ($past(state_ff) != S_IDLE))
      else $error("response strobe outside the end of a request");

   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_page_address == '0)
         && (count_ff == '0))
      else $error("empty status with a page or a nonzero count");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import pfla_pkg::*;

   localparam int PAGE_WORDS = 256;
   localparam int MAX_PAGES  = 1024;
   localparam addr_type PAGE_BYTES = addr_type'(PAGE_WORDS * 4);
   localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
   localparam int RANDOM_WORDS = 1025;
   localparam int PHASE_LEN = 150;
   localparam int DRAIN_CYCLES = 8;
   localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;

   typedef struct {
      addr_type            page_address;
      logic [STATUS_W-1:0] status;
      logic [PF_W-1:0]     pages_free;
   } alloc_result_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [OP_W-1:0]     req_operation;
   addr_type            req_address;
   addr_type            req_end_address;
   logic                rsp_valid;
   addr_type            rsp_page_address;
   logic [STATUS_W-1:0] rsp_status;
   logic [PF_W-1:0]     rsp_pages_free;

   // shadow of the free stack, updated when a word is accepted
   addr_type         page_stack [MAX_PAGES];
   int unsigned      stack_depth;
   alloc_result_type pending_results[$];
   addr_type         allocated_pages[$];
   alloc_result_type oldest;
   int unsigned      error_count;
   longint unsigned  cycle_count;
   bit               steady_run;

   page_free_list_allocator_unit #(
      .PAGE_WORDS(PAGE_WORDS),
      .MAX_PAGES (MAX_PAGES)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_address     (req_address),
      .req_end_address (req_end_address),
      .rsp_valid       (rsp_valid),
      .rsp_page_address(rsp_page_address),
      .rsp_status      (rsp_status),
      .rsp_pages_free  (rsp_pages_free)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic alloc_result_type predict_request(input logic [OP_W-1:0] op,
                                                        input addr_type addr,
                                                        input addr_type end_addr);
      alloc_result_type r;
      longint unsigned  p;
      r.page_address = '0;
      r.status       = ST_OK;
      case (op)
         OP_ALLOC: begin
            if (stack_depth == 0) begin
               r.status = ST_EMPTY;
            end else begin
               stack_depth--;
               r.page_address = page_stack[stack_depth] * PAGE_BYTES;
            end
         end
         OP_FREE: begin
            if (addr % PAGE_BYTES != 0) begin
               r.status = ST_MISALIGNED;
            end else if (stack_depth >= MAX_PAGES) begin
               r.status = ST_FULL;
            end else begin
               page_stack[stack_depth] = addr / PAGE_BYTES;
               stack_depth++;
            end
         end
         OP_FREE_RANGE: begin
            if (addr % PAGE_BYTES != 0 || end_addr % PAGE_BYTES != 0) begin
               r.status = ST_MISALIGNED;
            end else begin
               p = addr;
               while (p < end_addr) begin
                  if (stack_depth >= MAX_PAGES) begin
                     r.status = ST_FULL;
                     break;
                  end
                  page_stack[stack_depth] = addr_type'(p / PAGE_BYTES);
                  stack_depth++;
                  p += PAGE_BYTES;
               end
            end
         end
         default: begin
         end
      endcase
      r.pages_free = stack_depth[PF_W-1:0];
      return r;
   endfunction

   task automatic send_word(input logic [OP_W-1:0] op, input addr_type addr,
                            input addr_type end_addr);
      alloc_result_type r;
      start           <= 1'b1;
      req_operation   <= op;
      req_address     <= addr;
      req_end_address <= end_addr;
      do @(posedge clock); while (busy);
      r = predict_request(op, addr, end_addr);
      pending_results.push_back(r);
      if (op == OP_ALLOC && r.status == ST_OK) begin
         allocated_pages.push_back(r.page_address);
      end
      // the first cycle after acceptance is busy anyway
      if (!steady_run && $urandom_range(0, 99) < 20) begin
         start <= 1'b0;
         repeat ($urandom_range(2, 4)) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("response word with no request outstanding");
            error_count++;
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_page_address !== oldest.page_address) begin
               $error("page_address expected %h actual %h", oldest.page_address,
                      rsp_page_address);
               error_count++;
            end
            if (rsp_status !== oldest.status) begin
               $error("status expected %0d actual %0d", oldest.status, rsp_status);
               error_count++;
            end
            if (rsp_pages_free !== oldest.pages_free) begin
               $error("pages_free expected %0d actual %0d", oldest.pages_free,
                      rsp_pages_free);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_alloc();
      send_word(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_single_pages();
      send_word(OP_FREE, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_FREE, 32'hFFFF_FC00, 32'h0000_0000);
      send_word(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_misaligned();
      send_word(OP_FREE, 32'h0000_0200, 32'h0000_0000);
      send_word(OP_FREE, 32'h0000_0001, 32'h0000_0000);
      send_word(OP_FREE_RANGE, 32'h0000_0404, 32'h0000_1000);
      send_word(OP_FREE_RANGE, 32'h0000_0400, 32'hFFFF_FFFF);
   endtask

   task automatic test_ranges();
      send_word(OP_FREE_RANGE, 32'h0000_0800, 32'h0000_0800);
      send_word(OP_FREE_RANGE, 32'hFFFF_FC00, 32'h0000_0400);
      send_word(OP_FREE_RANGE, 32'h0000_0400, 32'h0000_1400);
      // highest page of the range must come back first
      send_word(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_unused_op();
      send_word(OP_RESERVED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
   endtask

   task automatic test_full_stack();
      // range runs into the top of the stack, the rest is dropped
      send_word(OP_FREE_RANGE, 32'h0000_0000, addr_type'(MAX_PAGES) * PAGE_BYTES);
      send_word(OP_FREE, 32'h0000_0400, 32'h0000_0000);
      send_word(OP_FREE_RANGE, 32'h0000_0000, 32'h0000_0800);
      send_word(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
      send_word(OP_FREE_RANGE, 32'h0001_0000, 32'h0001_0800);
      send_word(OP_ALLOC, 32'h0000_0000, 32'h0000_0000);
      // exactly fills the last slot
      send_word(OP_FREE_RANGE, 32'h0002_0000, 32'h0002_0400);
   endtask

   task automatic send_noise();
      addr_type base;
      case ($urandom_range(0, 4))
         0: send_word(OP_FREE, $urandom(), $urandom());
         1: send_word(OP_FREE_RANGE, $urandom(), $urandom());
         2: send_word(OP_RESERVED, $urandom(), $urandom());
         3: begin
            base = $urandom() & ~(PAGE_BYTES - 1);
            send_word(OP_FREE_RANGE, base,
                      base - PAGE_BYTES * addr_type'($urandom_range(0, 3)));
         end
         default: send_word(OP_ALLOC, $urandom(), $urandom());
      endcase
   endtask

   task automatic send_held_free();
      addr_type page;
      int       idx;
      if (allocated_pages.size() == 0) begin
         page = $urandom() & ~(PAGE_BYTES - 1);
      end else begin
         idx  = $urandom_range(0, allocated_pages.size() - 1);
         page = allocated_pages[idx];
         allocated_pages.delete(idx);
      end
      send_word(OP_FREE, page, $urandom());
   endtask

   task automatic send_range();
      addr_type base;
      int       pages;
      base  = $urandom() & ~(PAGE_BYTES - 1);
      pages = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
      send_word(OP_FREE_RANGE, base, base + PAGE_BYTES * addr_type'(pages));
   endtask

   task automatic test_random_traffic();
      int  pick;
      bit  draining;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // alternate between emptying and refilling the stack
         draining   = ((n / PHASE_LEN) % 2) == 0;
         steady_run = (n >= 2 * PHASE_LEN && n < 3 * PHASE_LEN);
         pick       = $urandom_range(0, 99);
         if (draining) begin
            if (pick < 70)      send_word(OP_ALLOC, $urandom(), $urandom());
            else if (pick < 85) send_held_free();
            else                send_noise();
         end else begin
            if (pick < 30)      send_word(OP_ALLOC, $urandom(), $urandom());
            else if (pick < 55) send_held_free();
            else if (pick < 85) send_range();
            else                send_noise();
         end
      end
      steady_run = 1'b0;
   endtask

   initial begin
      stack_depth     = 0;
      error_count     = 0;
      cycle_count     = 0;
      steady_run      = 1'b0;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_operation   <= OP_ALLOC;
      req_address     <= '0;
      req_end_address <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_empty_alloc();
      test_single_pages();
      test_misaligned();
      test_ranges();
      test_unused_op();
      test_full_stack();
      test_random_traffic();

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
